[hdl/sqtor_pkg.sv]
// Shared constants and types for the square table orientation read block.
`timescale 1ns / 1ps

package sqtor_pkg;

  localparam int SIDE_MAX_DEF   = 16;
  localparam int VALUE_BITS_DEF = 8;
  localparam int SIDE_RESET     = 16;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef enum logic [2:0] {
    ORIENT_ID     = 3'd0,
    ORIENT_ROT90  = 3'd1,
    ORIENT_ROT180 = 3'd2,
    ORIENT_ROT270 = 3'd3,
    ORIENT_FLIPX  = 3'd4,
    ORIENT_FLIPY  = 3'd5,
    ORIENT_TRANS  = 3'd6,
    ORIENT_ATRANS = 3'd7
  } orient_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic in_range;
  } sqtor_ctl_t;

endpackage

[hdl/sqtor_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module sqtor_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/sqtor_xform.sv]
// Input register and orientation address transform.
`timescale 1ns / 1ps

module sqtor_xform #(
  parameter int SIDE_MAX   = sqtor_pkg::SIDE_MAX_DEF,
  parameter int VALUE_BITS = sqtor_pkg::VALUE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    accept,
  input  logic                                    action,
  input  logic [2:0]                              orientation,
  input  logic [$clog2(SIDE_MAX)-1:0]             row,
  input  logic [$clog2(SIDE_MAX)-1:0]             col,
  input  logic [VALUE_BITS-1:0]                   value,
  input  logic [$clog2(SIDE_MAX+1)-1:0]           side,
  output sqtor_pkg::sqtor_ctl_t                   ctl,
  output logic [2*$clog2(SIDE_MAX)-1:0]           addr,
  output logic [VALUE_BITS-1:0]                   wdata
);

  import sqtor_pkg::*;

  localparam int RC_W = $clog2(SIDE_MAX);
  localparam int N_W  = $clog2(SIDE_MAX+1);
  localparam int AW   = 2 * RC_W;

  logic            in_vld;
  logic            in_act;
  orient_t         in_orient;
  logic [RC_W-1:0] in_row;
  logic [RC_W-1:0] in_col;
  logic [VALUE_BITS-1:0] in_val;

  logic [RC_W-1:0] m;
  logic [RC_W-1:0] mr;
  logic [RC_W-1:0] mc;
  logic [RC_W-1:0] sr;
  logic [RC_W-1:0] sc;
  logic            in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= accept;
    end
    if (accept) begin
      in_act    <= action;
      in_orient <= orient_t'(orientation);
      in_row    <= row;
      in_col    <= col;
      in_val    <= value;
    end
  end

  always_comb begin
    m        = RC_W'(side - N_W'(1));
    mr       = m - in_row;
    mc       = m - in_col;
    in_range = (N_W'(in_row) < side) && (N_W'(in_col) < side);
    sr       = in_row;
    sc       = in_col;
    if (in_act == ACT_READ) begin
      unique case (in_orient)
        ORIENT_ID:     begin sr = in_row; sc = in_col; end
        ORIENT_ROT90:  begin sr = in_col; sc = mr;     end
        ORIENT_ROT180: begin sr = mr;     sc = mc;     end
        ORIENT_ROT270: begin sr = mc;     sc = in_row; end
        ORIENT_FLIPX:  begin sr = mr;     sc = in_col; end
        ORIENT_FLIPY:  begin sr = in_row; sc = mc;     end
        ORIENT_TRANS:  begin sr = in_col; sc = in_row; end
        ORIENT_ATRANS: begin sr = mc;     sc = mr;     end
        default:       begin sr = in_row; sc = in_col; end
      endcase
    end
  end

  assign addr         = AW'(AW'(sr) * AW'(side)) + AW'(sc);
  assign wdata        = in_val;
  assign ctl.wr_en    = in_vld && (in_act == ACT_WRITE) && in_range;
  assign ctl.rd_en    = in_vld && (in_act == ACT_READ);
  assign ctl.in_range = in_range;

endmodule

[hdl/square_table_orientation_read.sv]
// Top level of the square table orientation read block.
`timescale 1ns / 1ps
//
// Holds an n by n table, row-major, with n in the side length register.
// Input channel: an item is taken at a clock edge with start high and busy
// low. action 0 writes value at (row, col); action 1 reads the entry that
// lands on output position (row, col) under the chosen orientation.
// Writes outside the table are dropped; reads outside the table give 0.
// Result channel: valid is high for exactly one cycle with entry, once a read
// passes the input and valid registers. Writes give no result. The receiver cannot stall.
// Throughput is one item per cycle, set by one address transform and one
// access of the single table RAM, write and read on separate ports.
// Configuration: cfg_ready is always high; cfg_data is written at an edge
// with cfg_valid high. 0 is taken as 1 and values above SIDE_MAX as SIDE_MAX.
// Reset: synchronous, clears the pipeline, sets the side length to 16 and
// holds busy high until the first edge out of reset. Table contents are undefined until written.
//
module square_table_orientation_read #(
  parameter int SIDE_MAX   = sqtor_pkg::SIDE_MAX_DEF,
  parameter int VALUE_BITS = sqtor_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action,
  input  logic [2:0]                    orientation,
  input  logic [$clog2(SIDE_MAX)-1:0]   row,
  input  logic [$clog2(SIDE_MAX)-1:0]   col,
  input  logic [VALUE_BITS-1:0]         value,
  output logic                          valid,
  output logic [VALUE_BITS-1:0]         entry,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [$clog2(SIDE_MAX+1)-1:0] cfg_data
);

  import sqtor_pkg::*;

  localparam int N_W       = $clog2(SIDE_MAX+1);
  localparam int AW        = 2 * $clog2(SIDE_MAX);
  localparam int CELLS     = 1 << AW;
  localparam int SIDE_INIT = (SIDE_RESET > SIDE_MAX) ? SIDE_MAX : SIDE_RESET;

  logic                  accept;
  logic [N_W-1:0]        side;
  logic [N_W-1:0]        side_next;
  sqtor_ctl_t            ctl;
  logic [AW-1:0]         addr;
  logic [VALUE_BITS-1:0] wdata;
  logic [VALUE_BITS-1:0] rdata;
  logic                  rd_in_range;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    side_next = cfg_data;
    if (cfg_data == '0) begin
      side_next = N_W'(1);
    end else if (cfg_data > N_W'(SIDE_MAX)) begin
      side_next = N_W'(SIDE_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b1;
      side        <= N_W'(SIDE_INIT);
      valid       <= 1'b0;
      rd_in_range <= 1'b0;
    end else begin
      busy        <= 1'b0;
      valid       <= ctl.rd_en;
      rd_in_range <= ctl.in_range;
      if (cfg_valid && cfg_ready) begin
        side <= side_next;
      end
    end
  end

  sqtor_xform #(
    .SIDE_MAX   (SIDE_MAX),
    .VALUE_BITS (VALUE_BITS)
  ) u_xform (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .action      (action),
    .orientation (orientation),
    .row         (row),
    .col         (col),
    .value       (value),
    .side        (side),
    .ctl         (ctl),
    .addr        (addr),
    .wdata       (wdata)
  );

  sqtor_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (addr),
    .wdata (wdata),
    .re    (ctl.rd_en),
    .raddr (addr),
    .rdata (rdata)
  );

  assign entry = rd_in_range ? rdata : '0;

  assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_READ) |-> ##2 valid)
    else $error("read item gave no result");

  assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_WRITE) |-> ##2 !valid)
    else $error("write item gave a result");

  assert property (@(posedge clk) disable iff (rst)
    (side != '0) && (side <= N_W'(SIDE_MAX)))
    else $error("side length out of range");

endmodule

[verif/square_table_orientation_read_tb.sv]
// Testbench for the square table orientation read block: directed and random items.
`timescale 1ns / 1ps

module square_table_orientation_read_tb;
  import sqtor_pkg::*;

  localparam int SIDE_MAX     = SIDE_MAX_DEF;
  localparam int VALUE_BITS   = VALUE_BITS_DEF;
  localparam int POS_BITS     = $clog2(SIDE_MAX);
  localparam int SIDE_BITS    = $clog2(SIDE_MAX + 1);
  localparam int CELLS        = SIDE_MAX * SIDE_MAX;
  localparam int SETTLE       = 4;
  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASE_ITEMS  = 11;

  typedef struct {
    logic                  action;
    orient_t               orientation;
    logic [POS_BITS-1:0]   row;
    logic [POS_BITS-1:0]   col;
    logic [VALUE_BITS-1:0] value;
  } table_item_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  action;
  logic [2:0]            orientation;
  logic [POS_BITS-1:0]   row;
  logic [POS_BITS-1:0]   col;
  logic [VALUE_BITS-1:0] value;
  logic                  valid;
  logic [VALUE_BITS-1:0] entry;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [SIDE_BITS-1:0]  cfg_data;

  logic [SIDE_BITS-1:0]  side_reg;
  logic [VALUE_BITS-1:0] table_mirror [CELLS];
  bit                    written [CELLS];
  logic [VALUE_BITS-1:0] entry_expected [$];
  logic [VALUE_BITS-1:0] entry_want;
  bit                    gaps_on;
  int                    fail_count;
  int                    cycle_count;

  square_table_orientation_read #(
    .SIDE_MAX  (SIDE_MAX),
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .orientation(orientation),
    .row        (row),
    .col        (col),
    .value      (value),
    .valid      (valid),
    .entry      (entry),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && valid) begin
      if (entry_expected.size() == 0) begin
        $error("entry: expected none, actual %0h", entry);
        fail_count++;
      end else begin
        entry_want = entry_expected.pop_front();
        if (entry !== entry_want) begin
          $error("entry: expected %0h, actual %0h", entry_want, entry);
          fail_count++;
        end
      end
    end
  end

  function automatic int unsigned active_side(logic [SIDE_BITS-1:0] s);
    if (s == 0) return 1;
    if (s > SIDE_MAX) return SIDE_MAX;
    return s;
  endfunction

  function automatic int unsigned source_addr(orient_t o, int unsigned r, int unsigned c,
                                              int unsigned n);
    int unsigned m;
    int unsigned sr;
    int unsigned sc;
    m = n - 1;
    case (o)
      ORIENT_ROT90: begin
        sr = c;     sc = m - r;
      end
      ORIENT_ROT180: begin
        sr = m - r; sc = m - c;
      end
      ORIENT_ROT270: begin
        sr = m - c; sc = r;
      end
      ORIENT_FLIPX: begin
        sr = m - r; sc = c;
      end
      ORIENT_FLIPY: begin
        sr = r;     sc = m - c;
      end
      ORIENT_TRANS: begin
        sr = c;     sc = r;
      end
      ORIENT_ATRANS: begin
        sr = m - c; sc = m - r;
      end
      default: begin
        sr = r;     sc = c;
      end
    endcase
    return sr * n + sc;
  endfunction

  function automatic table_item_t make_item(logic act, orient_t o, int unsigned r,
                                            int unsigned c, int unsigned v);
    table_item_t it;
    it.action      = act;
    it.orientation = o;
    it.row         = POS_BITS'(r);
    it.col         = POS_BITS'(c);
    it.value       = VALUE_BITS'(v);
    return it;
  endfunction

  task automatic predict_table_access(input table_item_t it);
    int unsigned n;
    int unsigned a;
    n = active_side(side_reg);
    if (it.action == ACT_WRITE) begin
      if (it.row < n && it.col < n) begin
        a = it.row * n + it.col;
        table_mirror[a] = it.value;
        written[a] = 1'b1;
      end
    end else if (it.row >= n || it.col >= n) begin
      entry_expected = {entry_expected, VALUE_BITS'(0)};
    end else begin
      a = source_addr(it.orientation, it.row, it.col, n);
      entry_expected = {entry_expected, table_mirror[a]};
    end
  endtask

  function automatic table_item_t random_table_item();
    table_item_t it;
    int unsigned n;
    int unsigned pick;
    int unsigned a;
    n = active_side(side_reg);
    pick = $urandom_range(0, 99);
    it.orientation = orient_t'($urandom_range(0, 7));
    it.value = VALUE_BITS'($urandom_range(0, (1 << VALUE_BITS) - 1));
    it.action = (pick < 30 || (pick >= 85 && pick < 92)) ? ACT_WRITE : ACT_READ;
    if (pick < 85 || n == SIDE_MAX) begin
      it.row = POS_BITS'($urandom_range(0, n - 1));
      it.col = POS_BITS'($urandom_range(0, n - 1));
    end else begin
      it.row = POS_BITS'($urandom_range(0, SIDE_MAX - 1));
      it.col = POS_BITS'($urandom_range(0, SIDE_MAX - 1));
      if (it.row < n && it.col < n) it.row = POS_BITS'($urandom_range(n, SIDE_MAX - 1));
    end
    if (it.action == ACT_READ && it.row < n && it.col < n) begin
      a = source_addr(it.orientation, it.row, it.col, n);
      if (!written[a]) begin
        it.action = ACT_WRITE;
        it.row = POS_BITS'(a / n);
        it.col = POS_BITS'(a % n);
      end
    end
    return it;
  endfunction

  task automatic send_item(input table_item_t it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    start       <= 1'b1;
    action      <= it.action;
    orientation <= it.orientation;
    row         <= it.row;
    col         <= it.col;
    value       <= it.value;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_table_access(it);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (entry_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_side(input logic [SIDE_BITS-1:0] s);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    side_reg = s;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_side();
    send_item(make_item(ACT_WRITE, ORIENT_ID, 15, 15, 8'hFF));
    send_item(make_item(ACT_WRITE, ORIENT_ATRANS, 0, 0, 8'h00));
    send_item(make_item(ACT_WRITE, ORIENT_ID, 0, 15, 8'hA5));
    send_item(make_item(ACT_WRITE, ORIENT_ID, 15, 0, 8'h5A));
    send_item(make_item(ACT_READ, ORIENT_ID, 15, 15, 8'h00));
    send_item(make_item(ACT_READ, ORIENT_ROT180, 0, 0, 8'hFF));
    send_item(make_item(ACT_READ, ORIENT_ROT90, 0, 0, 8'h3C));
    send_item(make_item(ACT_READ, ORIENT_ROT270, 0, 0, 8'hC3));
  endtask

  task automatic test_all_orientations();
    set_side(2);
    send_item(make_item(ACT_WRITE, ORIENT_ID, 0, 0, 8'h11));
    send_item(make_item(ACT_WRITE, ORIENT_ID, 0, 1, 8'h22));
    send_item(make_item(ACT_WRITE, ORIENT_ID, 1, 0, 8'h33));
    send_item(make_item(ACT_WRITE, ORIENT_ID, 1, 1, 8'h44));
    for (int o = 0; o < 8; o++) begin
      send_item(make_item(ACT_READ, orient_t'(o), 0, 1, $urandom_range(0, 255)));
    end
  endtask

  task automatic test_out_of_range();
    send_item(make_item(ACT_WRITE, ORIENT_ID, 2, 0, 8'hEE));
    send_item(make_item(ACT_READ, ORIENT_ID, 1, 0, 8'h00));
    send_item(make_item(ACT_READ, ORIENT_TRANS, 0, 2, 8'h00));
    send_item(make_item(ACT_READ, ORIENT_ATRANS, 15, 15, 8'hFF));
  endtask

  task automatic test_side_clamp();
    set_side(0);
    send_item(make_item(ACT_WRITE, ORIENT_ID, 0, 0, 8'h96));
    send_item(make_item(ACT_READ, ORIENT_ROT90, 0, 0, 8'h00));
    send_item(make_item(ACT_READ, ORIENT_ID, 1, 0, 8'h00));
    set_side(31);
    send_item(make_item(ACT_READ, ORIENT_ID, 15, 15, 8'h00));
  endtask

  task automatic test_fill();
    for (int a = 0; a < CELLS; a++) begin
      send_item(make_item(ACT_WRITE, orient_t'($urandom_range(0, 7)), a / SIDE_MAX,
                          a % SIDE_MAX, $urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_sides();
    logic [SIDE_BITS-1:0] sides [10];
    sides = '{16, 1, 3, 31, 8, 0, 5, 17, 2, 15};
    for (int p = 0; p < 11; p++) begin
      if (p < 10) set_side(sides[p]);
      else begin
        set_side(SIDE_BITS'($urandom_range(0, 31)));
        gaps_on = 1'b0;
      end
      repeat (PHASE_ITEMS) send_item(random_table_item());
    end
  endtask

  initial begin
    rst         <= 1'b1;
    start       <= 1'b0;
    action      <= ACT_WRITE;
    orientation <= ORIENT_ID;
    row         <= '0;
    col         <= '0;
    value       <= '0;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    cycle_count = 0;
    fail_count  = 0;
    gaps_on     = 1'b1;
    side_reg    = SIDE_BITS'(SIDE_RESET);
    for (int a = 0; a < CELLS; a++) begin
      table_mirror[a] = '0;
      written[a] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_side();
    test_all_orientations();
    test_out_of_range();
    test_side_clamp();
    test_fill();
    test_random_sides();
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
